@@ hdl/sfcc_pkg.sv @@
// Shared types, constants and the CRC-8 byte update for the sensor frame
// CRC check and conversion unit. Depends on nothing; every other file but sfcc_checker uses it.
package sfcc_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned RawW   = 16;
	localparam int unsigned GainW  = 18;
	localparam int unsigned ValueW = 18;
	localparam int unsigned ProdW  = RawW + GainW;

	localparam logic [8:0]         CrcPolyFull = 9'h131;
	localparam logic [ByteW-1:0]   CrcTopBit   = 8'h80;
	localparam logic [ByteW-1:0]   CrcInit     = 8'h00;
	localparam logic [ByteW-1:0]   StatusMask  = 8'hFC;
	localparam logic [GainW-1:0]   TempGain    = 18'd175720;
	localparam logic [ValueW:0]    TempOffset  = 19'd46850;
	localparam logic [GainW-1:0]   HumGain     = 18'd125000;
	localparam logic [ValueW:0]    HumOffset   = 19'd6000;

	// Measurement kind codes.
	localparam logic KindTemp = 1'b0;
	localparam logic KindHum  = 1'b1;

	// Byte position within a frame. The fourth code of the two-bit field
	// is never entered and is handled like the MSB position.
	typedef enum logic [1:0] {
		POS_MSB   = 2'd0,
		POS_LSB   = 2'd1,
		POS_CHECK = 2'd2
	} byte_pos_t;

	// A finished frame handed from the frame tracker to the scaler.
	typedef struct packed {
		logic [RawW-1:0] raw;
		logic            kind;
		logic            crc_error;
	} frame_result_t;

	// MSB-first CRC-8 over one byte, polynomial 0x31, no final xor.
	function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc,
		input logic [ByteW-1:0] b);
		logic [ByteW-1:0] c;
		c = crc ^ b;
		for (int k = 0; k < ByteW; k++) begin
			if ((c & CrcTopBit) != '0) begin
				c = {c[ByteW-2:0], 1'b0} ^ CrcPolyFull[ByteW-1:0];
			end else begin
				c = {c[ByteW-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ hdl/sfcc_frame.sv @@
// Frame tracker: input register, byte position, running CRC and stored data
// bytes; emits one finished frame per checksum byte. Uses sfcc_pkg.
module sfcc_frame (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            data_byte,
	input  logic                  measure_kind,
	input  logic                  frame_start,
	output logic                  res_valid,
	output sfcc_pkg::frame_result_t res,
	input  logic                  res_take
);

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        kind_s1;
	logic        start_s1;

	sfcc_pkg::byte_pos_t pos_q, pos_eff, pos_next;
	logic [7:0]  crc_q;
	logic [7:0]  high_q;
	logic [7:0]  low_q;
	logic        kind_q;

	logic        en_s1, en_s2, step;
	logic        done;
	logic [7:0]  crc_upd;

	assign en_s2    = !res_valid || res_take;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;
	assign step     = v_s1 && en_s2;

	// A start mark always restarts the frame at the MSB.
	always_comb begin
		if (start_s1) begin
			pos_eff = sfcc_pkg::POS_MSB;
		end else begin
			case (pos_q)
				sfcc_pkg::POS_LSB:   pos_eff = sfcc_pkg::POS_LSB;
				sfcc_pkg::POS_CHECK: pos_eff = sfcc_pkg::POS_CHECK;
				default:             pos_eff = sfcc_pkg::POS_MSB;
			endcase
		end
	end

	// Next position.
	always_comb begin
		case (pos_eff)
			sfcc_pkg::POS_MSB:   pos_next = sfcc_pkg::POS_LSB;
			sfcc_pkg::POS_LSB:   pos_next = sfcc_pkg::POS_CHECK;
			default:             pos_next = sfcc_pkg::POS_MSB;
		endcase
	end

	// Outputs of the position sequencer.
	always_comb begin
		case (pos_eff)
			sfcc_pkg::POS_MSB: begin
				done    = 1'b0;
				crc_upd = sfcc_pkg::crc8_byte(sfcc_pkg::CrcInit, byte_s1);
			end
			sfcc_pkg::POS_LSB: begin
				done    = 1'b0;
				crc_upd = sfcc_pkg::crc8_byte(crc_q, byte_s1);
			end
			default: begin
				done    = 1'b1;
				crc_upd = crc_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			byte_s1  <= data_byte;
			kind_s1  <= measure_kind;
			start_s1 <= frame_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= sfcc_pkg::POS_MSB;
			crc_q  <= sfcc_pkg::CrcInit;
			high_q <= '0;
			low_q  <= '0;
			kind_q <= sfcc_pkg::KindTemp;
		end else if (step) begin
			pos_q <= pos_next;
			crc_q <= crc_upd;
			if (pos_eff == sfcc_pkg::POS_MSB) begin
				high_q <= byte_s1;
				kind_q <= kind_s1;
			end
			if (pos_eff == sfcc_pkg::POS_LSB) begin
				low_q <= byte_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en_s2) begin
			res_valid <= step && done;
		end
	end

	always_ff @(posedge clk) begin
		if (step && done) begin
			res.raw       <= {high_q, low_q & sfcc_pkg::StatusMask};
			res.kind      <= kind_q;
			res.crc_error <= (byte_s1 != crc_q);
		end
	end

endmodule

@@ hdl/sfcc_scale.sv @@
// Scaler and output register: converts a raw sensor word into milli-units
// with one multiply, then holds the result for the output channel. Uses sfcc_pkg.
module sfcc_scale (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    res_valid,
	input  sfcc_pkg::frame_result_t res,
	output logic                    res_take,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [17:0]      scaled_value,
	output logic                    crc_error,
	output logic                    value_kind
);

	logic [sfcc_pkg::GainW-1:0]  gain;
	logic [sfcc_pkg::ValueW:0]   offset;
	logic [sfcc_pkg::ProdW-1:0]  product;
	logic [sfcc_pkg::ValueW:0]   value;

	assign res_take = !out_valid || !out_stall;

	always_comb begin
		if (res.kind == sfcc_pkg::KindHum) begin
			gain   = sfcc_pkg::HumGain;
			offset = sfcc_pkg::HumOffset;
		end else begin
			gain   = sfcc_pkg::TempGain;
			offset = sfcc_pkg::TempOffset;
		end
		product = {{sfcc_pkg::GainW{1'b0}}, res.raw} * {{sfcc_pkg::RawW{1'b0}}, gain};
		// The shifted product is below 2^18, so one zero bit on top keeps it positive.
		value   = {1'b0, product[sfcc_pkg::ProdW-1:16]} - offset;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_take) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			scaled_value <= signed'(value[sfcc_pkg::ValueW-1:0]);
			crc_error    <= res.crc_error;
			value_kind   <= res.kind;
		end
	end

endmodule

@@ hdl/sensor_frame_crc_check_convert_unit.sv @@
// Top level of the sensor frame CRC check and conversion unit.
// Instantiates sfcc_frame and sfcc_scale; uses sfcc_pkg.
//
// The unit takes the three bytes of a humidity/temperature sensor reading,
// one byte per input transfer: data MSB, data LSB, then the checksum. It
// checks the checksum against an MSB-first CRC-8 (polynomial 0x31, init 0)
// of the two data bytes and, on the checksum byte only, delivers one output
// transfer: the reading in milli-degrees Celsius or milli-percent relative
// humidity as an 18-bit two's complement value, the kind of the reading
// (sampled with the MSB), and a flag that is set when the checksum did not
// match; the value is delivered even then. The two status bits of the raw
// word are cleared before scaling. Asserting frame_start on any byte starts
// a new frame with that byte as the MSB, discarding a partial frame. The
// unit accepts one byte in every clock cycle while in_stall is low. A
// checksum byte is first held in the input register; the frame tracker
// then writes its CRC compare into its result register, and the scaler
// then writes the multiply into the output register. Each stage only
// waits when the stage after it is full and stalled, so bytes keep being
// accepted while a result waits to be taken, as long as an earlier stage
// has room.
module sensor_frame_crc_check_convert_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               measure_kind,
	input  logic               frame_start,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [17:0] scaled_value,
	output logic               crc_error,
	output logic               value_kind
);

	// Finished frame moving from the tracker to the scaler.
	sfcc_pkg::frame_result_t res;
	logic                    res_valid;
	logic                    res_take;

	// Byte position, running CRC and the stored data bytes live here.
	sfcc_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.measure_kind (measure_kind),
		.frame_start  (frame_start),
		.res_valid    (res_valid),
		.res          (res),
		.res_take     (res_take)
	);

	// Gain multiply, offset subtract and the output register.
	sfcc_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res          (res),
		.res_take     (res_take),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.scaled_value (scaled_value),
		.crc_error    (crc_error),
		.value_kind   (value_kind)
	);

endmodule

@@ hdl/sfcc_checker.sv @@
// Port-level checks for the sensor frame CRC check and conversion unit,
// bound to the top level. Depends only on the top level's ports.
module sfcc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [17:0] scaled_value,
	input logic               crc_error,
	input logic               value_kind
);

	// A stalled result stays offered.
	a_out_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output transfer withdrawn while stalled");

	// A stalled result does not change.
	a_out_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(scaled_value) && $stable(crc_error)
			&& $stable(value_kind))
		else $error("output payload changed while stalled");

	// With the output register empty, every stage can move, so input is taken.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while the output register is empty");

	// Scaled values stay within the reachable range of both conversions.
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (scaled_value >= -18'sd46850) && (scaled_value <= 18'sd128861))
		else $error("scaled value out of range");

endmodule

bind sensor_frame_crc_check_convert_unit sfcc_checker u_sfcc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.scaled_value (scaled_value),
	.crc_error    (crc_error),
	.value_kind   (value_kind)
);
